// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, request and command codes, cell constants and the
// command record that travels from the front end to the engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int CURSOR_W = 11;
  localparam int ADDR_W   = CURSOR_W;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int ATTR_W   = 2 * COLOR_W;
  localparam int TAB_W    = 5;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int BIT_W    = $clog2(CURSOR_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TAB_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_STOP   = 2'd2;

  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;
  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;
  localparam logic [TAB_W-1:0]   TAB_STOP_RESET   = 5'd4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Character and cell constants
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, CHAR_BLANK};

  // Address landmarks
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] CURSOR_END = ADDR_W'(CELL_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ROW   = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);

  // Queue between front end and engine
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    CMD_CHAR    = 3'd0,
    CMD_NEWLINE = 3'd1,
    CMD_TAB     = 3'd2,
    CMD_READ    = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_NOP     = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] idx;
    logic              in_range;
  } cmd_t;

endpackage

// ----- rtl/tcw_in_if.sv -----
// ----------------------------------------------------------------------------
// tcw_in_if: request channel of the text console writer
// Valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  import tcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [CHAR_W-1:0]   char_code;
  logic [CURSOR_W-1:0] cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);

endinterface

// ----- rtl/tcw_out_if.sv -----
// ----------------------------------------------------------------------------
// tcw_out_if: result channel of the text console writer
// Valid/ready handshake with the cell data and cursor position.
// ----------------------------------------------------------------------------
interface tcw_out_if;
  import tcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CELL_W-1:0]   cell_data;
  logic [CURSOR_W-1:0] cursor_position;

  modport source (output valid, cell_data, cursor_position, input ready);
  modport sink   (input valid, cell_data, cursor_position, output ready);

endinterface

// ----- rtl/text_console_writer.sv -----
// Work per request: a newline blanks one cell at a time up to the row end, a tab
//   first finds the distance to the next stop and then blanks one cell at a
//   time, a scroll moves the store cell by cell and a clear blanks every cell.
// Intake: one request in the engine at a time, and the store has a single write
//   port; the front stage and a 4-entry queue take up to 5 requests ahead.
// Reset: a clearing pass blanks the store; in_req.ready stays low.
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Keeps an 80x25 screen of attribute/character cells and a cursor; puts
// characters (with newline, tab and scroll), clears the screen and reads
// single cells, answering every request with one result.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                             clk,
  input  logic                             rst_n,
  tcw_in_if.sink                           in_req,
  tcw_out_if.source                        out_res,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tcw_pkg::*;

  // Configuration registers
  logic [COLOR_W-1:0] background_r;
  logic [COLOR_W-1:0] foreground_r;
  logic [TAB_W-1:0]   tab_stop_r;

  // Front end to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // Queue to engine
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Engine status back to the front end
  logic init_busy;

  // The user must make configuration writes only while the engine is idle;
  // the block does not enforce it. The engine reads these registers directly
  // without a shadow copy. Writes to an index beyond the list drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      background_r <= BACKGROUND_RESET;
      foreground_r <= FOREGROUND_RESET;
      tab_stop_r   <= TAB_STOP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKGROUND: background_r <= cfg_wdata[COLOR_W-1:0];
        CFG_FOREGROUND: foreground_r <= cfg_wdata[COLOR_W-1:0];
        CFG_TAB_STOP:   tab_stop_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: register each request and decode it into a command
  // (printable, newline, tab, read, clear, or no-op for the unused code).
  tcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .init_busy  (init_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Queue: decouple intake from the engine so either side can stall alone.
  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Engine: screen store, cursor, scroll/fill/clear sequencer and the
  // output register. A scroll copies each row up through the registered
  // read port, then blanks the bottom row with the current attribute.
  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .head      (pop_cmd),
    .attr      ({background_r, foreground_r}),
    .tab_stop  (tab_stop_r),
    .init_busy (init_busy),
    .out_res   (out_res)
  );

endmodule

// ----- rtl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front: request intake and classification
// Registers each request and decodes it into an engine command.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic          clk,
  input  logic          rst_n,
  tcw_in_if.sink        in_req,
  input  logic          init_busy,
  output logic          push_valid,
  input  logic          push_ready,
  output tcw_pkg::cmd_t push_cmd
);
  import tcw_pkg::*;

  logic st_valid_r;
  cmd_t st_cmd_r;
  cmd_t cmd_nxt;
  logic accept;

  always_comb begin
    cmd_nxt.ch       = in_req.char_code;
    cmd_nxt.idx      = in_req.cell_index;
    cmd_nxt.in_range = (in_req.cell_index < CURSOR_END);
    unique case (in_req.req_type)
      REQ_PUT: begin
        priority if (in_req.char_code == CHAR_NEWLINE) cmd_nxt.kind = CMD_NEWLINE;
        else if (in_req.char_code == CHAR_TAB) cmd_nxt.kind = CMD_TAB;
        else cmd_nxt.kind = CMD_CHAR;
      end
      REQ_READ:  cmd_nxt.kind = CMD_READ;
      REQ_CLEAR: cmd_nxt.kind = CMD_CLEAR;
      default:   cmd_nxt.kind = CMD_NOP;
    endcase
  end

  // take a request when not clearing and the stage is empty or drains this cycle
  assign in_req.ready = !init_busy && (!st_valid_r || push_ready);
  assign accept       = in_req.valid && in_req.ready;
  assign push_valid   = st_valid_r;
  assign push_cmd     = st_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_valid_r <= 1'b1;
        st_cmd_r   <= cmd_nxt;
      end else if (push_ready) begin
        st_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// tcw_queue: command queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tcw_pkg::cmd_t pop_cmd
);
  import tcw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        slots_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r          <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back: console engine
// Owns the screen store and cursor, runs one command at a time and
// holds its result in the output register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  tcw_pkg::cmd_t                head,
  input  logic [tcw_pkg::ATTR_W-1:0]   attr,
  input  logic [tcw_pkg::TAB_W-1:0]    tab_stop,
  output logic                         init_busy,
  tcw_out_if.source                    out_res
);
  import tcw_pkg::*;

  typedef enum logic [9:0] {
    ST_INIT     = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_READ     = 10'b00_0000_0100,
    ST_SCROLL   = 10'b00_0000_1000,
    ST_BLANKROW = 10'b00_0001_0000,
    ST_PUT      = 10'b00_0010_0000,
    ST_TABMOD   = 10'b00_0100_0000,
    ST_FILL     = 10'b00_1000_0000,
    ST_CLEAR    = 10'b01_0000_0000,
    ST_RESULT   = 10'b10_0000_0000
  } state_t;

  logic [CELL_W-1:0]   screen [CELL_COUNT];
  logic [CELL_W-1:0]   rdata_r;

  state_t              state_r;
  state_t              state_nxt;
  cmd_t                cmd_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   cursor_r;
  logic [COL_W-1:0]    col_r;
  logic                cp_pend_r;
  logic [ADDR_W-1:0]   cp_waddr_r;
  logic [TAB_W-1:0]    rem_r;
  logic [BIT_W-1:0]    bit_r;
  logic [TAB_W-1:0]    run_r;
  logic [CELL_W-1:0]   res_data_r;
  logic                out_valid_r;
  logic [CELL_W-1:0]   out_data_r;
  logic [CURSOR_W-1:0] out_cursor_r;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CELL_W-1:0]   blank_cell;
  logic [TAB_W-1:0]    spacing;
  logic [TAB_W:0]      rem_sh;
  logic [TAB_W:0]      rem_n;
  logic                scroll_rd;
  logic                fill_done;
  logic                out_free;
  logic [ADDR_W-1:0]   cursor_inc;
  logic [COL_W-1:0]    col_inc;

  assign blank_cell = {attr, CHAR_BLANK};
  assign spacing    = (tab_stop == '0) ? TAB_W'(1) : tab_stop;
  assign rem_sh     = {rem_r, cursor_r[bit_r]};
  assign rem_n      = (rem_sh >= {1'b0, spacing}) ? (rem_sh - {1'b0, spacing}) : rem_sh;
  assign scroll_rd  = (addr_r < LAST_ROW);
  assign fill_done  = (cmd_r.kind == CMD_NEWLINE) ? (col_r == COL_LAST)
                                                  : ((run_r == TAB_W'(1)) ||
                                                     (cursor_r == LAST_CELL));
  assign out_free   = !out_valid_r || out_res.ready;
  assign cursor_inc = cursor_r + ADDR_W'(1);
  assign col_inc    = (col_r == COL_LAST) ? '0 : (col_r + COL_W'(1));

  assign pop_ready  = (state_r == ST_IDLE);
  assign init_busy  = (state_r == ST_INIT);

  assign out_res.valid           = out_valid_r;
  assign out_res.cell_data       = out_data_r;
  assign out_res.cursor_position = out_cursor_r;

  // next state and store port controls
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = head.idx;
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_BLANK;
        if (addr_r == LAST_CELL) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop_valid) begin
          case (head.kind)
            CMD_CHAR, CMD_NEWLINE, CMD_TAB: begin
              state_nxt = (cursor_r == CURSOR_END) ? ST_SCROLL : ST_PUT;
            end
            CMD_READ: begin
              if (head.in_range) begin
                mem_re    = 1'b1;
                state_nxt = ST_READ;
              end else begin
                state_nxt = ST_RESULT;
              end
            end
            CMD_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_READ: state_nxt = ST_RESULT;
      ST_SCROLL: begin
        // read one row ahead, write the cell back in the next cycle
        mem_we    = cp_pend_r;
        mem_waddr = cp_waddr_r;
        mem_wdata = rdata_r;
        mem_re    = scroll_rd;
        mem_raddr = addr_r + ADDR_W'(COLUMNS);
        if (!scroll_rd) state_nxt = ST_BLANKROW;
      end
      ST_BLANKROW: begin
        mem_we = 1'b1;
        if (addr_r == LAST_CELL) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        case (cmd_r.kind)
          CMD_NEWLINE: state_nxt = ST_FILL;
          CMD_TAB:     state_nxt = ST_TABMOD;
          default: begin
            mem_we    = 1'b1;
            mem_waddr = cursor_r;
            mem_wdata = {attr, cmd_r.ch};
            state_nxt = ST_RESULT;
          end
        endcase
      end
      ST_TABMOD: begin
        if (bit_r == '0) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_r;
        if (fill_done) state_nxt = ST_RESULT;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == LAST_CELL) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= screen[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load a new result, else drop the one just taken
      if ((state_r == ST_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_res.valid && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: addr_r <= addr_r + ADDR_W'(1);
        ST_IDLE: begin
          if (pop_valid) begin
            cmd_r      <= head;
            res_data_r <= '0;
            addr_r     <= '0;
            cp_pend_r  <= 1'b0;
          end
        end
        ST_READ: res_data_r <= rdata_r;
        ST_SCROLL: begin
          cp_pend_r  <= scroll_rd;
          cp_waddr_r <= addr_r;
          addr_r     <= scroll_rd ? (addr_r + ADDR_W'(1)) : LAST_ROW;
        end
        ST_BLANKROW: begin
          addr_r <= addr_r + ADDR_W'(1);
          if (addr_r == LAST_CELL) begin
            cursor_r <= LAST_ROW;
            col_r    <= '0;
          end
        end
        ST_PUT: begin
          case (cmd_r.kind)
            CMD_NEWLINE: ;
            CMD_TAB: begin
              rem_r <= '0;
              bit_r <= BIT_W'(CURSOR_W - 1);
            end
            default: begin
              cursor_r <= cursor_inc;
              col_r    <= col_inc;
            end
          endcase
        end
        ST_TABMOD: begin
          rem_r <= rem_n[TAB_W-1:0];
          bit_r <= bit_r - BIT_W'(1);
          if (bit_r == '0) run_r <= spacing - rem_n[TAB_W-1:0];
        end
        ST_FILL: begin
          cursor_r <= cursor_inc;
          col_r    <= col_inc;
          run_r    <= run_r - TAB_W'(1);
        end
        ST_CLEAR: addr_r <= addr_r + ADDR_W'(1);
        ST_RESULT: begin
          if (out_free) begin
            out_data_r   <= res_data_r;
            out_cursor_r <= cursor_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CURSOR_END)
    else $error("cursor beyond screen end");

  a_end_col: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r == CURSOR_END) |-> (col_r == '0))
    else $error("column out of step with cursor at screen end");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !out_valid_r)
    else $error("result during clearing pass");

  a_tab_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && cmd_r.kind == CMD_TAB) |-> (run_r != '0))
    else $error("tab run exhausted while filling");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the text console writer
// Drives put, read, clear and unused requests through the request channel,
// keeps its own copy of the screen, cursor and color/tab registers, and checks
// every result against it under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  // The one request code the block leaves unused
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // The limit between handshakes must outlast a scroll, a clear and the
  // clearing pass after reset, the longest waits of the block.
  localparam int WATCHDOG_LIMIT = 20000;
  // Longest single operation plus margin, spent after the last result.
  localparam int DRAIN_CYCLES   = 2100;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [CHAR_W-1:0]   ch;
    logic [CURSOR_W-1:0] idx;
  } console_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]   cell_word;
    logic [CURSOR_W-1:0] cursor;
  } console_ans_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  text_console_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_if),
    .out_res   (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Screen model: cells, cursor and the three registers as the block sees them
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0]  screen_model [CELL_COUNT];
  int unsigned        cursor_model;
  logic [COLOR_W-1:0] back_color;
  logic [COLOR_W-1:0] fore_color;
  logic [TAB_W-1:0]   tab_spacing;
  int unsigned        scroll_count;
  int unsigned        clear_count;

  // Requests waiting for the driver, and console answers waiting for the block
  console_req_t request_queue [$];
  console_ans_t answer_queue [$];

  // Handshake bookkeeping
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned in_gap;
  int unsigned out_stall;
  logic        in_fire;
  logic        out_fire;
  int unsigned idle_cycles;
  int unsigned requests_taken;
  int unsigned answers_checked;
  int unsigned error_count;
  int unsigned settings_used;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {back_color, fore_color, CHAR_BLANK};
  endfunction

  // Blank a run of cells, never past the last one
  function automatic void blank_run(int unsigned from, int unsigned count);
    for (int unsigned k = 0; k < count && from + k < CELL_COUNT; k++)
      screen_model[from + k] = blank_cell();
  endfunction

  // Move every row up by one, blank the bottom row, park the cursor on it
  function automatic void scroll_screen();
    for (int unsigned k = 0; k + COLUMNS < CELL_COUNT; k++)
      screen_model[k] = screen_model[k + COLUMNS];
    blank_run(CELL_COUNT - COLUMNS, COLUMNS);
    cursor_model = CELL_COUNT - COLUMNS;
    scroll_count++;
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] ch);
    int unsigned step;
    int unsigned stop;
    if (cursor_model >= CELL_COUNT)
      scroll_screen();
    if (ch == CHAR_NEWLINE) begin
      // Pad to the row end; the cursor may land exactly on the screen end
      step = COLUMNS - cursor_model % COLUMNS;
      blank_run(cursor_model, step);
      cursor_model += step;
    end else if (ch == CHAR_TAB) begin
      // A spacing of zero behaves like one; the run is clipped at screen end
      step = (tab_spacing == '0) ? 1 : tab_spacing;
      stop = cursor_model + step - cursor_model % step;
      if (stop > CELL_COUNT)
        stop = CELL_COUNT;
      blank_run(cursor_model, stop - cursor_model);
      cursor_model = stop;
    end else begin
      screen_model[cursor_model] = {back_color, fore_color, ch};
      cursor_model++;
    end
  endfunction

  // Apply one request to the screen model and return the answer it must give
  function automatic console_ans_t console_apply(console_req_t r);
    console_ans_t a;
    a.cell_word = '0;
    case (r.kind)
      REQ_PUT:   put_char(r.ch);
      REQ_READ:  if (r.idx < CELL_COUNT) a.cell_word = screen_model[r.idx];
      REQ_CLEAR: begin
        blank_run(0, CELL_COUNT);
        clear_count++;
      end
      default: ;
    endcase
    a.cursor = CURSOR_W'(cursor_model);
    return a;
  endfunction

  task automatic flag_error(string msg);
    if (error_count < MAX_PRINTED)
      $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_request(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                        logic [CURSOR_W-1:0] idx);
    console_req_t r;
    r.kind = kind;
    r.ch   = ch;
    r.idx  = idx;
    request_queue.push_back(r);
  endfunction

  // Any byte but newline and tab, so the cursor moves by exactly one
  function automatic logic [CHAR_W-1:0] random_printable();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom_range(255, 0));
    if (ch == CHAR_TAB || ch == CHAR_NEWLINE)
      ch = CHAR_BLANK;
    return ch;
  endfunction

  // Puts carry a random cell index and reads a random byte: toggle the
  // unused fields too, the block must ignore them.
  function automatic void queue_put(logic [CHAR_W-1:0] ch);
    queue_request(REQ_PUT, ch, CURSOR_W'($urandom_range(2047, 0)));
  endfunction

  function automatic void queue_read(logic [CURSOR_W-1:0] idx);
    queue_request(REQ_READ, CHAR_W'($urandom_range(255, 0)), idx);
  endfunction

  // Mostly puts; reads, rare clears and the odd unused code mixed in.
  // newline_weight is in tenths of a percent.
  function automatic console_req_t random_request(int unsigned newline_weight);
    console_req_t r;
    int unsigned  pick;
    pick  = $urandom_range(999, 0);
    r.ch  = CHAR_W'($urandom_range(255, 0));
    r.idx = CURSOR_W'($urandom_range(2047, 0));
    if (pick < 10) begin
      r.kind = REQ_CLEAR;
    end else if (pick < 30) begin
      r.kind = REQ_UNUSED;
    end else if (pick < 180) begin
      r.kind = REQ_READ;
      // keep most reads on the screen, a few past its end
      if ($urandom_range(19, 0) != 0)
        r.idx = CURSOR_W'($urandom_range(CELL_COUNT - 1, 0));
    end else begin
      r.kind = REQ_PUT;
      if (pick < 180 + newline_weight)
        r.ch = CHAR_NEWLINE;
      else if (pick < 280 + newline_weight)
        r.ch = CHAR_TAB;
    end
    return r;
  endfunction

  task automatic queue_random(int unsigned count, int unsigned newline_weight);
    repeat (count) request_queue.push_back(random_request(newline_weight));
  endtask

  // Hold until the driver is empty and every answer has come back
  task automatic wait_idle();
    while (request_queue.size() != 0 || in_if.valid || answer_queue.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BACKGROUND: back_color  = val[COLOR_W-1:0];
      CFG_FOREGROUND: fore_color  = val[COLOR_W-1:0];
      CFG_TAB_STOP:   tab_spacing = val[TAB_W-1:0];
      default: ;
    endcase
  endtask

  // Write all three registers back to back, then drop the write enable
  task automatic configure(logic [COLOR_W-1:0] back, logic [COLOR_W-1:0] fore,
                           logic [TAB_W-1:0] spacing);
    write_reg(CFG_BACKGROUND, CFG_DATA_W'(back));
    write_reg(CFG_FOREGROUND, CFG_DATA_W'(fore));
    write_reg(CFG_TAB_STOP, CFG_DATA_W'(spacing));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Walk the cursor to the screen end with newlines, then work the bottom
  // row: scroll on a plain character, fill to the last tab stop, clip a tab
  // at the end, scroll on a tab and on a newline. Call only while idle, so
  // the model cursor is exact, and with a nonzero tab spacing.
  task automatic walk_to_bottom();
    int unsigned spot;
    int unsigned last_stop;
    spot = cursor_model;
    while (spot < CELL_COUNT) begin
      queue_put(CHAR_NEWLINE);
      spot = (spot / COLUMNS + 1) * COLUMNS;
    end
    queue_put(random_printable());
    last_stop = (CELL_COUNT / tab_spacing) * tab_spacing;
    if (last_stop > CELL_COUNT - COLUMNS + 1)
      repeat (last_stop - (CELL_COUNT - COLUMNS + 1)) queue_put(random_printable());
    queue_put(CHAR_TAB);
    queue_put(CHAR_TAB);
    queue_put(CHAR_NEWLINE);
    queue_put(CHAR_NEWLINE);
    queue_read(LAST_ROW);
    queue_read(LAST_CELL);
    queue_read(CURSOR_W'(LAST_ROW - 1));
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver: present the next queued request at the falling edge and
  // hold it until it is taken; then idle for the gap drawn with it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    console_req_t nxt;
    logic         holding;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      holding = in_if.valid && !in_fire;
      if (!holding) begin
        if (in_gap != 0) begin
          in_if.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (request_queue.size() != 0) begin
          nxt = request_queue.pop_front();
          in_if.valid      <= 1'b1;
          in_if.req_type   <= nxt.kind;
          in_if.char_code  <= nxt.ch;
          in_if.cell_index <= nxt.idx;
          in_gap           <= $urandom_range(in_gap_max, 0);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result ready: after each result, drop ready for a drawn number of cycles
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    int unsigned stall;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      stall = out_fire ? $urandom_range(out_gap_max, 0) : out_stall;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        out_stall    <= stall - 1;
      end else begin
        out_if.ready <= 1'b1;
        out_stall    <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at the rising edge, check a taken result against the oldest
  // answer, then run a taken request through the screen model.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    console_ans_t want;
    console_req_t taken;
    in_fire  <= rst_n && in_if.valid && in_if.ready;
    out_fire <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (answer_queue.size() == 0) begin
        flag_error($sformatf("result with no request outstanding: cell %h cursor %0d",
                             out_if.cell_data, out_if.cursor_position));
      end else begin
        want = answer_queue.pop_front();
        if (out_if.cell_data !== want.cell_word)
          flag_error($sformatf("result %0d: cell_data %h, want %h",
                               answers_checked, out_if.cell_data, want.cell_word));
        if (out_if.cursor_position !== want.cursor)
          flag_error($sformatf("result %0d: cursor_position %0d, want %0d",
                               answers_checked, out_if.cursor_position, want.cursor));
        answers_checked++;
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      taken.kind = in_if.req_type;
      taken.ch   = in_if.char_code;
      taken.idx  = in_if.cell_index;
      answer_queue.push_back(console_apply(taken));
      requests_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles in which neither channel moves a request or result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles without a handshake, %0d results outstanding",
               idle_cycles, answer_queue.size());
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_BACKGROUND;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.req_type   = REQ_PUT;
    in_if.char_code  = '0;
    in_if.cell_index = '0;
    out_if.ready     = 1'b0;
    in_fire          = 1'b0;
    out_fire         = 1'b0;
    in_gap           = 0;
    out_stall        = 0;
    idle_cycles      = 0;
    requests_taken   = 0;
    answers_checked  = 0;
    error_count      = 0;
    settings_used    = 0;
    scroll_count     = 0;
    clear_count      = 0;
    in_gap_max       = 10;
    out_gap_max      = 10;

    // Model state after reset: blank cells with the reset attribute
    back_color   = BACKGROUND_RESET;
    fore_color   = FOREGROUND_RESET;
    tab_spacing  = TAB_STOP_RESET;
    cursor_model = 0;
    for (int unsigned k = 0; k < CELL_COUNT; k++)
      screen_model[k] = RESET_BLANK;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, read range edges, byte extremes, tab stops,
    // newline padding, the unused code and a clear, under reset registers.
    queue_read(CURSOR_W'(0));
    queue_read(LAST_CELL);
    queue_read(CURSOR_END);
    queue_read(CURSOR_W'(2047));
    queue_put(8'h41);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(CHAR_TAB);
    queue_put(CHAR_TAB);
    queue_request(REQ_PUT, 8'h42, CURSOR_W'(2047));
    queue_put(CHAR_NEWLINE);
    queue_put(CHAR_NEWLINE);
    queue_read(CURSOR_W'(0));
    queue_read(CURSOR_W'(1));
    queue_read(CURSOR_W'(2));
    queue_read(CURSOR_W'(8));
    queue_read(CURSOR_W'(COLUMNS));
    queue_request(REQ_UNUSED, 8'hFF, CURSOR_W'(2047));
    queue_request(REQ_UNUSED, 8'h00, CURSOR_W'(0));
    queue_request(REQ_CLEAR, 8'hFF, CURSOR_W'(2047));
    queue_read(CURSOR_W'(0));
    queue_read(LAST_CELL);

    // Extreme colors, widest normal tab spacing
    wait_idle();
    configure(4'd15, 4'd0, 5'd16);
    queue_random(300, 60);

    // Zero tab spacing; no idling on either side
    wait_idle();
    configure(4'd5, 4'd10, 5'd0);
    in_gap_max  = 0;
    out_gap_max = 0;
    queue_random(250, 60);

    // Largest spacing; full-rate sender into a stalling receiver. Work the
    // bottom of the screen before the random mix.
    wait_idle();
    configure(4'd9, 4'd3, 5'd31);
    out_gap_max = 10;
    walk_to_bottom();
    queue_random(250, 120);

    // Random colors, tab on every cell; slow sender, eager receiver
    wait_idle();
    configure(COLOR_W'($urandom_range(15, 0)), COLOR_W'($urandom_range(15, 0)), 5'd1);
    in_gap_max  = 10;
    out_gap_max = 0;
    queue_random(280, 60);

    // Back to the reset colors with an odd spacing; idle on both sides
    wait_idle();
    configure(4'd0, 4'd15, 5'd3);
    out_gap_max = 10;
    queue_random(260, 80);

    // Drain, then give a stray result time to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: %0d requests under %0d register settings, %0d results checked",
             requests_taken, settings_used, answers_checked);
    $display("summary: %0d scrolls, %0d clears, %0d mismatches",
             scroll_count, clear_count, error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
